[rtl/core/sph_pkg.sv]
// Shared types and constants for the screen point to hex cell block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sph_pkg;

    // Register file layout
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_LAYOUT   = 3'd0;
    localparam logic [2:0] REG_VP_WIDTH = 3'd1;
    localparam logic [2:0] REG_VP_HGT   = 3'd2;
    localparam logic [2:0] REG_ZOOM     = 3'd3;
    localparam logic [2:0] REG_OFFSET_X = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y = 3'd5;

    // Field widths
    localparam int SCREEN_W = 16;
    localparam int VP_W     = 14;
    localparam int ZOOM_W   = 24;
    localparam int WORLD_W  = 32;
    localparam int CELL_W   = 17;

    // Centred half-pixel value: 18-bit signed, magnitude fits 17 bits
    localparam int CTR_W = 18;
    localparam int MAG_W = 17;

    // Reciprocal layout scales, unsigned Q1.30
    localparam int RECIP_FRAC = 30;
    localparam int RECIP_W    = 31;
    localparam logic [RECIP_W-1:0] INV_SQRT3_Q30  = 31'd619925131;
    localparam logic [RECIP_W-1:0] TWO_THIRDS_Q30 = 31'd715827883;
    localparam logic [RECIP_W-1:0] ONE_Q30        = 31'd1073741824;

    localparam int ZOOM_FRAC = 16;

    // Cube coordinate work width: 2*wx - wy and friends
    localparam int CUBE_W = 34;

    // Layout mode codes
    localparam logic LAYOUT_HEX  = 1'b0;
    localparam logic LAYOUT_RECT = 1'b1;

    // Reset values
    localparam logic [VP_W-1:0]   VP_WIDTH_RST  = 14'd1024;
    localparam logic [VP_W-1:0]   VP_HEIGHT_RST = 14'd768;
    localparam logic [ZOOM_W-1:0] ZOOM_RST      = 24'd65536;

    typedef struct packed {
        logic                      layout_mode;
        logic [VP_W-1:0]           viewport_width;
        logic [VP_W-1:0]           viewport_height;
        logic [ZOOM_W-1:0]         zoom_reciprocal;
        logic signed [WORLD_W-1:0] offset_x;
        logic signed [WORLD_W-1:0] offset_y;
    } cfg_t;

endpackage

[rtl/core/sph_cfg.sv]
// Configuration register file with an APB-style slave port.
// Depends on sph_pkg for the register map and the cfg_t bundle.
`timescale 1ns / 1ps

module sph_cfg
    import sph_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic                      layout_mode_reg;
    logic [VP_W-1:0]           vp_width_reg;
    logic [VP_W-1:0]           vp_height_reg;
    logic [ZOOM_W-1:0]         zoom_reg;
    logic signed [WORLD_W-1:0] offset_x_reg;
    logic signed [WORLD_W-1:0] offset_y_reg;

    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Register writes; unmapped indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_mode_reg <= LAYOUT_HEX;
            vp_width_reg    <= VP_WIDTH_RST;
            vp_height_reg   <= VP_HEIGHT_RST;
            zoom_reg        <= ZOOM_RST;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LAYOUT:   layout_mode_reg <= pwdata[0];
                REG_VP_WIDTH: vp_width_reg    <= pwdata[VP_W-1:0];
                REG_VP_HGT:   vp_height_reg   <= pwdata[VP_W-1:0];
                REG_ZOOM:     zoom_reg        <= pwdata[ZOOM_W-1:0];
                REG_OFFSET_X: offset_x_reg    <= pwdata;
                REG_OFFSET_Y: offset_y_reg    <= pwdata;
                default:      ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_LAYOUT:   prdata = {31'd0, layout_mode_reg};
            REG_VP_WIDTH: prdata = {18'd0, vp_width_reg};
            REG_VP_HGT:   prdata = {18'd0, vp_height_reg};
            REG_ZOOM:     prdata = {8'd0, zoom_reg};
            REG_OFFSET_X: prdata = offset_x_reg;
            REG_OFFSET_Y: prdata = offset_y_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.layout_mode     = layout_mode_reg;
    assign cfg.viewport_width  = vp_width_reg;
    assign cfg.viewport_height = vp_height_reg;
    assign cfg.zoom_reciprocal = zoom_reg;
    assign cfg.offset_x        = offset_x_reg;
    assign cfg.offset_y        = offset_y_reg;

endmodule

[rtl/core/sph_world.sv]
// Screen to world transform: centre, scale by layout and zoom reciprocals,
// translate and saturate. Five register stages; depends on sph_pkg.
`timescale 1ns / 1ps

module sph_world
    import sph_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SCREEN_W-1:0] screen_x,
    input  logic signed [SCREEN_W-1:0] screen_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [WORLD_W-1:0]  world_x,
    output logic signed [WORLD_W-1:0]  world_y
);

    localparam int PW = MAG_W + RECIP_W;              // scale product
    localparam int SH = RECIP_FRAC + 1 - FRAC_BITS;   // drop to FRAC_BITS
    localparam int AW = PW - SH + 1;                  // rounded scale
    localparam int ZW = AW + ZOOM_W;                  // zoom product
    localparam int BW = ZW - ZOOM_FRAC + 1;           // rounded zoom
    localparam int SW = BW + 2;                       // signed sum

    // Stage valids and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5     = !v5_reg || out_ready;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // Centring in half pixels, Y flipped
    logic signed [CTR_W-1:0] ctr [2];
    assign ctr[0] = {screen_x[SCREEN_W-1], screen_x, 1'b0} - {4'd0, cfg.viewport_width};
    assign ctr[1] = {4'd0, cfg.viewport_height} - {screen_y[SCREEN_W-1], screen_y, 1'b0};

    // Per-axis lane constants
    logic [RECIP_W-1:0]        recip  [2];
    logic                      flip   [2];
    logic signed [WORLD_W-1:0] offset [2];

    always_comb
    begin
        recip[0]  = (cfg.layout_mode == LAYOUT_RECT) ? ONE_Q30 : INV_SQRT3_Q30;
        recip[1]  = (cfg.layout_mode == LAYOUT_RECT) ? ONE_Q30 : TWO_THIRDS_Q30;
        flip[0]   = 1'b0;
        flip[1]   = (cfg.layout_mode == LAYOUT_HEX);
        offset[0] = cfg.offset_x;
        offset[1] = cfg.offset_y;
    end

    logic signed [WORLD_W-1:0] world_reg [2];

    for (genvar ln = 0; ln < 2; ln++)
    begin : g_lane
        logic [MAG_W-1:0] mag1_reg;
        logic             neg1_reg, neg2_reg, neg3_reg, neg4_reg;
        logic [PW-1:0]    p2_reg;
        logic [AW-1:0]    a3_reg;
        logic [ZW-1:0]    z4_reg;

        logic [MAG_W-1:0]        mag_next;
        logic [PW:0]             p_rnd;
        logic [ZW:0]             z_rnd;
        logic [BW-1:0]           b_mag;
        logic signed [SW-1:0]    b_sgn;
        logic signed [SW-1:0]    w_sum;
        logic signed [WORLD_W-1:0] w_next;

        // Stage 1: magnitude and sign of the centred value
        assign mag_next = ctr[ln][CTR_W-1] ? MAG_W'(-ctr[ln]) : ctr[ln][MAG_W-1:0];

        // Stage 3: round the scale product to FRAC_BITS
        assign p_rnd = {1'b0, p2_reg} + ((PW+1)'(1) << (SH-1));

        // Stage 5: round the zoom product, sign, translate, saturate
        assign z_rnd = {1'b0, z4_reg} + ((ZW+1)'(1) << (ZOOM_FRAC-1));
        assign b_mag = z_rnd[ZW:ZOOM_FRAC];
        assign b_sgn = neg4_reg ? -SW'(b_mag) : SW'(b_mag);
        assign w_sum = b_sgn + SW'(offset[ln]);

        always_comb
        begin
            if (!w_sum[SW-1] && (|w_sum[SW-2:WORLD_W-1]))
                w_next = {1'b0, {(WORLD_W-1){1'b1}}};
            else if (w_sum[SW-1] && !(&w_sum[SW-2:WORLD_W-1]))
                w_next = {1'b1, {(WORLD_W-1){1'b0}}};
            else
                w_next = w_sum[WORLD_W-1:0];
        end

        // Datapath registers
        always_ff @(posedge clk)
        begin
            if (adv1)
            begin
                mag1_reg <= mag_next;
                neg1_reg <= ctr[ln][CTR_W-1] ^ flip[ln];
            end
            if (adv2)
            begin
                p2_reg   <= PW'(mag1_reg) * PW'(recip[ln]);
                neg2_reg <= neg1_reg;
            end
            if (adv3)
            begin
                a3_reg   <= p_rnd[PW:SH];
                neg3_reg <= neg2_reg;
            end
            if (adv4)
            begin
                z4_reg   <= ZW'(a3_reg) * ZW'(cfg.zoom_reciprocal);
                neg4_reg <= neg3_reg;
            end
            if (adv5)
                world_reg[ln] <= w_next;
        end
    end

    assign world_x = world_reg[0];
    assign world_y = world_reg[1];

endmodule

[rtl/core/sph_hex.sv]
// Cube-coordinate hex rounding and odd-row offset conversion.
// Three register stages; the last is the output register. Depends on sph_pkg.
`timescale 1ns / 1ps

module sph_hex
    import sph_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [WORLD_W-1:0] world_x,
    input  logic signed [WORLD_W-1:0] world_y,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [WORLD_W-1:0] out_world_x,
    output logic signed [WORLD_W-1:0] out_world_y,
    output logic signed [CELL_W-1:0]  hex_col,
    output logic signed [CELL_W-1:0]  hex_row
);

    localparam int G  = FRAC_BITS + 1;               // cube fraction bits
    localparam int XM = CUBE_W - 1;                  // cube magnitude width
    localparam int KU = CUBE_W - G;                  // rounded magnitude
    localparam int KW = KU + 1;                      // rounded, signed
    localparam int CW = (KW + 2 > CELL_W + 1) ? KW + 2 : CELL_W + 1;

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    assign adv3      = !v3_reg || out_ready;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign in_ready  = adv1;
    assign out_valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // Stage 1: doubled cube coordinates q, r, s (lanes 0, 1, 2)
    logic signed [CUBE_W-1:0] wx2, wy1, cube [3];
    assign wx2     = {world_x[WORLD_W-1], world_x, 1'b0};
    assign wy1     = {{2{world_y[WORLD_W-1]}}, world_y};
    assign cube[0] = wx2 - wy1;
    assign cube[1] = {world_y[WORLD_W-1], world_y, 1'b0};
    assign cube[2] = -wx2 - wy1;

    logic signed [WORLD_W-1:0] wx1_reg, wy1_reg, wx2_reg, wy2_reg;
    logic signed [KW-1:0]      ki2_reg  [3];
    logic [G-1:0]              err2_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            wx1_reg <= world_x;
            wy1_reg <= world_y;
        end
        if (adv2)
        begin
            wx2_reg <= wx1_reg;
            wy2_reg <= wy1_reg;
        end
    end

    for (genvar ln = 0; ln < 3; ln++)
    begin : g_axis
        logic [XM-1:0]       mag1_reg;
        logic                neg1_reg;
        logic [CUBE_W-1:0]   rnd;
        logic [KU-1:0]       k;
        logic [CUBE_W-1:0]   kg;
        logic [CUBE_W-1:0]   mag_ext;
        logic [CUBE_W-1:0]   err;

        // Stage 2: round half away from zero, error against the exact value
        assign rnd     = {1'b0, mag1_reg} + (CUBE_W'(1) << (G-1));
        assign k       = rnd[CUBE_W-1:G];
        assign kg      = {k, {G{1'b0}}};
        assign mag_ext = {1'b0, mag1_reg};
        assign err     = (kg >= mag_ext) ? kg - mag_ext : mag_ext - kg;

        always_ff @(posedge clk)
        begin
            if (adv1)
            begin
                mag1_reg <= cube[ln][CUBE_W-1] ? XM'(-cube[ln]) : cube[ln][XM-1:0];
                neg1_reg <= cube[ln][CUBE_W-1];
            end
            if (adv2)
            begin
                ki2_reg[ln]  <= neg1_reg ? -KW'(k) : KW'(k);
                err2_reg[ln] <= err[G-1:0];
            end
        end
    end

    // Clamp to the cell range
    function automatic logic [CELL_W-1:0] sat_cell(input logic signed [CW-1:0] v);
        if (!v[CW-1] && (|v[CW-2:CELL_W-1]))
            return {1'b0, {(CELL_W-1){1'b1}}};
        else if (v[CW-1] && !(&v[CW-2:CELL_W-1]))
            return {1'b1, {(CELL_W-1){1'b0}}};
        else
            return v[CELL_W-1:0];
    endfunction

    // Stage 3: rebuild the worst component, then offset column
    logic signed [CW-1:0] qe, re, se, q_fix, r_fix, col;
    logic                 fix_q, fix_r;

    always_comb
    begin
        qe    = CW'(ki2_reg[0]);
        re    = CW'(ki2_reg[1]);
        se    = CW'(ki2_reg[2]);
        fix_q = (err2_reg[0] > err2_reg[1]) && (err2_reg[0] > err2_reg[2]);
        fix_r = !fix_q && (err2_reg[1] > err2_reg[2]);
        q_fix = fix_q ? -re - se : qe;
        r_fix = fix_r ? -q_fix - se : re;
        col   = q_fix + (r_fix >>> 1);
    end

    logic signed [CELL_W-1:0]  col_reg, row_reg;
    logic signed [WORLD_W-1:0] wx3_reg, wy3_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            col_reg <= sat_cell(col);
            row_reg <= sat_cell(r_fix);
            wx3_reg <= wx2_reg;
            wy3_reg <= wy2_reg;
        end
    end

    assign hex_col     = col_reg;
    assign hex_row     = row_reg;
    assign out_world_x = wx3_reg;
    assign out_world_y = wy3_reg;

endmodule

[rtl/core/screen_point_to_hex_cell_top.sv]
// Screen point to hex cell: a screen pixel position in, world position and
// hex cell out through an eight-stage pipeline. A request passes through the
// sph_world stages, then the sph_hex stages, to its result on m_axis; the
// rate is one request per clock while m_axis is ready, since every stage
// hands its point on each cycle and the two multipliers (layout scale, then
// zoom) each sit in a stage of their own. Back-pressure on m_axis holds each
// stage in place and lets bubbles close up, so the input keeps taking requests
// while the output waits until all eight stages hold a request. The user must
// write registers over the APB port only while no request is in flight; the
// block does not enforce this. FRAC_BITS sets the fraction bits of world_x,
// world_y and the offsets. Depends on sph_pkg, sph_cfg, sph_world and sph_hex.
`timescale 1ns / 1ps

module screen_point_to_hex_cell_top
    import sph_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [15:0] screen_x, [31:16] screen_y
    // Output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [103:0]      m_axis_tdata    // [31:0] world_x, [63:32] world_y,
                                              // [80:64] hex_col, [97:81] hex_row,
                                              // [103:98] zero
);

    cfg_t cfg;

    logic                      mid_valid, mid_ready;
    logic signed [WORLD_W-1:0] mid_wx, mid_wy;
    logic signed [WORLD_W-1:0] out_wx, out_wy;
    logic signed [CELL_W-1:0]  out_col, out_row;

    sph_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sph_world #(
        .FRAC_BITS (FRAC_BITS)
    ) u_world (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .screen_x  (s_axis_tdata[15:0]),
        .screen_y  (s_axis_tdata[31:16]),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .world_x   (mid_wx),
        .world_y   (mid_wy)
    );

    sph_hex #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hex (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (mid_valid),
        .in_ready    (mid_ready),
        .world_x     (mid_wx),
        .world_y     (mid_wy),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_world_x (out_wx),
        .out_world_y (out_wy),
        .hex_col     (out_col),
        .hex_row     (out_row)
    );

    assign m_axis_tdata = {6'd0, out_row, out_col, out_wy, out_wx};

endmodule
